// ===== src/q4k_pkg.sv =====
`default_nettype none

package q4k_pkg;

    localparam int VALUES_PER_BLOCK = 256;
    localparam int WORD_W           = 64;
    localparam int VALUE_W          = 26;
    localparam int FIX_W            = 16;
    localparam int SCALE_W          = 6;
    localparam int QUANT_W          = 4;
    localparam int COEF_W           = FIX_W + SCALE_W;          // d*sc, dmin*m
    localparam int PROD_W           = COEF_W + QUANT_W + 1;     // coef*q, with headroom
    localparam int HALF_GROUP       = 32;
    localparam int IDX_W            = $clog2(HALF_GROUP);
    localparam int POS_W            = 5;
    localparam int GROUPS           = VALUES_PER_BLOCK / (2 * HALF_GROUP);
    localparam int GROUP_W          = $clog2(GROUPS);

    localparam logic [POS_W-1:0]   POS_HEADER = POS_W'(0);
    localparam logic [POS_W-1:0]   POS_SCALES = POS_W'(1);
    localparam logic [POS_W-1:0]   POS_FIRST_DATA = POS_W'(2);
    localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(VALUES_PER_BLOCK / 16 + 1);
    localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(HALF_GROUP - 1);
    localparam logic [GROUP_W-1:0] GROUP_LAST = GROUP_W'(GROUPS - 1);
    localparam logic [1:0]         SLOT_LAST = 2'd3;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_PREP,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic                accept;
        logic [POS_W-1:0]    pos;
        logic                prep;
        logic                half;
        logic [GROUP_W-1:0]  group;
        logic                emit;
        logic [IDX_W-1:0]    idx;
        logic                group_last;
        logic                block_last;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_space;
    } status_t;

    typedef struct packed {
        logic [SCALE_W-1:0] sc;
        logic [SCALE_W-1:0] mn;
    } pair_t;

    // 6-bit scale/min pair of sub-block j from the 12 packed scale bytes
    function automatic pair_t unpack_pair(input logic [11:0][7:0] s, input logic [2:0] j);
        pair_t      p;
        logic [3:0] k;
        k = {2'b00, j[1:0]};
        if (!j[2]) begin
            p.sc = s[k][5:0];
            p.mn = s[k + 4'd4][5:0];
        end
        else begin
            p.sc = {s[k][7:6], s[k + 4'd8][3:0]};
            p.mn = {s[k + 4'd4][7:6], s[k + 4'd8][7:4]};
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== src/q4k_if.sv =====
`default_nettype none

interface q4k_word_if;
    import q4k_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data_word;

    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);
endinterface

interface q4k_value_if;
    import q4k_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      group_last;
    logic                      block_last;

    modport source (output valid, output value, output group_last, output block_last,
                    input ready);
    modport sink   (input valid, input value, input group_last, input block_last,
                    output ready);
endinterface

`default_nettype wire

// ===== src/q4k_ctrl.sv =====
`default_nettype none

module q4k_ctrl
    import q4k_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t sts,
    output cmd_t         cmd
);

    state_t              state_reg, state_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                half_reg, half_next;
    logic [GROUP_W-1:0]  group_reg, group_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    logic                accept;
    logic                emit;
    logic                group_word;
    logic [POS_W-1:0]    data_pos;

    assign accept     = in_valid && (state_reg == ST_COLLECT);
    assign emit       = (state_reg == ST_EMIT) && sts.out_space;
    assign data_pos   = pos_reg - POS_FIRST_DATA;
    // words 5, 9, 13, 17 close a group of four data words
    assign group_word = (pos_reg >= POS_FIRST_DATA) && (data_pos[1:0] == SLOT_LAST);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_COLLECT;
            pos_reg   <= POS_HEADER;
            half_reg  <= 1'b0;
            group_reg <= '0;
            idx_reg   <= '0;
        end
        else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            half_reg  <= half_next;
            group_reg <= group_next;
            idx_reg   <= idx_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        half_next  = half_reg;
        group_next = group_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_COLLECT: begin
                if (accept) begin
                    pos_next = (pos_reg >= POS_LAST) ? POS_HEADER : pos_reg + POS_W'(1);
                    if (group_word) begin
                        state_next = ST_PREP;
                        half_next  = 1'b0;
                        group_next = data_pos[GROUP_W+1:2];
                    end
                end
            end
            ST_PREP: begin
                state_next = ST_EMIT;
                idx_next   = '0;
            end
            ST_EMIT: begin
                if (emit) begin
                    idx_next = idx_reg + IDX_W'(1);
                    if (idx_reg == IDX_LAST) begin
                        if (!half_reg) begin
                            half_next  = 1'b1;
                            state_next = ST_PREP;
                        end
                        else begin
                            state_next = ST_COLLECT;
                        end
                    end
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    // outputs
    always_comb begin
        in_ready       = (state_reg == ST_COLLECT);
        cmd.accept     = accept;
        cmd.pos        = pos_reg;
        cmd.prep       = (state_reg == ST_PREP);
        cmd.half       = half_reg;
        cmd.group      = group_reg;
        cmd.emit       = emit;
        cmd.idx        = idx_reg;
        cmd.group_last = half_reg && (idx_reg == IDX_LAST);
        cmd.block_last = half_reg && (idx_reg == IDX_LAST) && (group_reg == GROUP_LAST);
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("word position out of range");

    a_block_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pos_reg == POS_LAST) |=> (pos_reg == POS_HEADER && state_reg == ST_PREP))
        else $error("last word did not wrap and start a group");

    a_prep_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP) |=> (state_reg == ST_EMIT && idx_reg == '0))
        else $error("prep not followed by emit from index zero");

    a_group_done: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && half_reg && idx_reg == IDX_LAST) |=> (state_reg == ST_COLLECT))
        else $error("controller did not return to collect after a group");

endmodule

`default_nettype wire

// ===== src/q4k_datapath.sv =====
`default_nettype none

module q4k_datapath
    import q4k_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [WORD_W-1:0] data_word,
    input  wire cmd_t              cmd,
    output status_t                sts,
    q4k_value_if.source            result
);

    logic signed [FIX_W-1:0]   d_reg;
    logic signed [FIX_W-1:0]   dmin_reg;
    logic [11:0][7:0]          scales_reg;
    logic [WORD_W-1:0]         nibble_reg [4];
    logic signed [COEF_W-1:0]  a_reg, a_next;
    logic signed [COEF_W-1:0]  b_reg, b_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic                      group_last_reg;
    logic                      block_last_reg;

    logic [POS_W-1:0]          data_pos;
    pair_t                     pair;
    logic [WORD_W-1:0]         cur_word;
    logic [7:0]                cur_byte;
    logic [QUANT_W-1:0]        q;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  diff;

    assign data_pos = cmd.pos - POS_FIRST_DATA;

    // payload capture
    always_ff @(posedge clk) begin
        if (cmd.accept) begin
            if (cmd.pos == POS_HEADER) begin
                d_reg            <= data_word[15:0];
                dmin_reg         <= data_word[31:16];
                scales_reg[3:0]  <= data_word[63:32];
            end
            else if (cmd.pos == POS_SCALES) begin
                scales_reg[11:4] <= data_word;
            end
            else begin
                nibble_reg[data_pos[1:0]] <= data_word;
            end
        end
        if (cmd.prep) begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
        if (cmd.emit) begin
            value_reg      <= value_next;
            group_last_reg <= cmd.group_last;
            block_last_reg <= cmd.block_last;
        end
    end

    // per-half coefficients: d*sc and dmin*m
    always_comb begin
        pair   = unpack_pair(scales_reg, {cmd.group, cmd.half});
        a_next = COEF_W'(d_reg * $signed({1'b0, pair.sc}));
        b_next = COEF_W'(dmin_reg * $signed({1'b0, pair.mn}));
    end

    // one value per emit: a*q - b
    always_comb begin
        cur_word   = nibble_reg[cmd.idx[4:3]];
        cur_byte   = cur_word[{cmd.idx[2:0], 3'b000} +: 8];
        q          = cmd.half ? cur_byte[7:4] : cur_byte[3:0];
        prod       = PROD_W'(a_reg * $signed({1'b0, q}));
        diff       = prod - PROD_W'(b_reg);
        value_next = diff[VALUE_W-1:0];
    end

    assign sts.out_space = !out_valid_reg || result.ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end
        else if (result.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.value      = value_reg;
    assign result.group_last = group_last_reg;
    assign result.block_last = block_last_reg;

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted value not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !cmd.emit)
        else $error("emit overwrote a stalled result");

endmodule

`default_nettype wire

// ===== src/q4k_block_dequantizer.sv =====
// Q4_K super-block dequantizer
//
//   channel       dir  payload                              transfer
//   quant_words   in   data_word[63:0]                      valid & ready
//   dequant_vals  out  value[25:0] s, group_last, block_last valid & ready
//
// Words 0, 1 and the data words that do not close a group are just captured.
// A group-closing word (5, 9, 13, 17) is accepted; then, per half, ST_PREP forms
// d*sc and dmin*m and ST_EMIT produces the half's values one by one through the
// single a*q - b multiplier. Output backpressure holds the emit sequencer; input
// is refused while a group drains. rst_n is asynchronous, active low; it clears
// control state only.
`default_nettype none

module q4k_block_dequantizer
    import q4k_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    q4k_word_if.sink    quant_words,
    q4k_value_if.source dequant_vals
);

    cmd_t    cmd;
    status_t sts;
    logic    in_ready;

    // sequencing: word position, group/half, emit index
    q4k_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (quant_words.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    assign quant_words.ready = in_ready;

    // scale store, nibble buffer, coefficient and value arithmetic, output register
    q4k_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_word (quant_words.data_word),
        .cmd       (cmd),
        .sts       (sts),
        .result    (dequant_vals)
    );

endmodule

`default_nettype wire

// ===== tb/q4k_dequant_checker.sv =====
`timescale 1ns / 1ps

module q4k_dequant_checker
    import q4k_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    q4k_word_if  words,
    q4k_value_if vals,
    output int   mismatches,
    output int   pending,
    output int   checked
);

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      group_last;
        logic                      block_last;
    } dq_value_t;

    // keep the log short on a badly broken design; every mismatch is still counted
    localparam int MAX_PRINTED = 40;

    dq_value_t               expected_vals [$];
    logic [POS_W-1:0]        word_pos;
    logic signed [FIX_W-1:0] d_fix;
    logic signed [FIX_W-1:0] dmin_fix;
    logic [7:0]              scale_bytes [12];
    logic [WORD_W-1:0]       quant_buf [4];

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < MAX_PRINTED)
        begin
            $display("%0t MISMATCH %s: got %0d, expected %0d (value #%0d)",
                     $time, what, got, want, checked);
        end
        mismatches++;
    endtask

    // 6-bit scale and min of sub-block j
    function automatic void scale_min_of(input int j, output int sc, output int mn);
        if (j < 4)
        begin
            sc = scale_bytes[j][5:0];
            mn = scale_bytes[j + 4][5:0];
        end
        else
        begin
            sc = {scale_bytes[j - 4][7:6], scale_bytes[j + 4][3:0]};
            mn = {scale_bytes[j][7:6], scale_bytes[j + 4][7:4]};
        end
    endfunction

    task automatic predict_word(input logic [WORD_W-1:0] w);
        logic [1:0] slot;
        int         grp;
        int         sc_lo;
        int         mn_lo;
        int         sc_hi;
        int         mn_hi;
        longint     a_lo;
        longint     b_lo;
        longint     a_hi;
        longint     b_hi;
        longint     v;
        logic [7:0] qbyte;
        dq_value_t  e;
        if (word_pos == POS_HEADER)
        begin
            d_fix    = w[15:0];
            dmin_fix = w[31:16];
            for (int i = 0; i < 4; i++)
                scale_bytes[i] = w[32 + 8 * i +: 8];
        end
        else if (word_pos == POS_SCALES)
        begin
            for (int i = 0; i < 8; i++)
                scale_bytes[4 + i] = w[8 * i +: 8];
        end
        else
        begin
            slot = 2'(word_pos - POS_FIRST_DATA);
            quant_buf[slot] = w;
            if (slot == SLOT_LAST)
            begin
                grp = int'(word_pos - POS_FIRST_DATA) >> 2;
                scale_min_of(2 * grp, sc_lo, mn_lo);
                scale_min_of(2 * grp + 1, sc_hi, mn_hi);
                a_lo = longint'(d_fix) * sc_lo;
                b_lo = longint'(dmin_fix) * mn_lo;
                a_hi = longint'(d_fix) * sc_hi;
                b_hi = longint'(dmin_fix) * mn_hi;
                // low nibbles of the 32 bytes first, then the high nibbles
                for (int i = 0; i < 64; i++)
                begin
                    qbyte = quant_buf[(i % 32) / 8][8 * (i % 8) +: 8];
                    if (i < 32)
                        v = a_lo * longint'(qbyte[3:0]) - b_lo;
                    else
                        v = a_hi * longint'(qbyte[7:4]) - b_hi;
                    e.value      = v[VALUE_W-1:0];
                    e.group_last = (i == 63);
                    e.block_last = (i == 63) && (word_pos == POS_LAST);
                    expected_vals.push_back(e);
                end
            end
        end
        word_pos = (word_pos == POS_LAST) ? POS_HEADER : word_pos + 1'b1;
    endtask

    task automatic check_value(input logic signed [VALUE_W-1:0] got_v, input logic gl,
                               input logic bl);
        dq_value_t e;
        if (expected_vals.size() == 0)
        begin
            report_mismatch("value with nothing expected", longint'(got_v), 0);
        end
        else
        begin
            e = expected_vals.pop_front();
            if (got_v !== e.value)
                report_mismatch("value", longint'(got_v), longint'(e.value));
            if (gl !== e.group_last)
                report_mismatch("group_last", gl, e.group_last);
            if (bl !== e.block_last)
                report_mismatch("block_last", bl, e.block_last);
        end
        checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_pos = POS_HEADER;
            d_fix    = '0;
            dmin_fix = '0;
            expected_vals.delete();
            pending  = 0;
        end
        else
        begin
            if (words.valid && words.ready)
                predict_word(words.data_word);
            if (vals.valid && vals.ready)
                check_value(vals.value, vals.group_last, vals.block_last);
            pending = expected_vals.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the Q4_K super-block dequantizer.
// Words go in whole 18-word super-blocks; the checker beside the DUT predicts
// the 64-value groups and compares every output transaction.
module tb;
    import q4k_pkg::*;

    localparam int WORDS_PER_BLOCK = 18;
    localparam int RANDOM_BLOCKS   = 8;
    // a group-closing word keeps the DUT busy until all 64 of its values are emitted
    localparam int DRAIN_CYCLES    = 100;

    logic clk;
    logic rst_n;
    int   value_mismatches;
    int   values_pending;
    int   values_checked;
    int   blocks_sent;

    logic [WORD_W-1:0] block_words [WORDS_PER_BLOCK];

    q4k_word_if  quant_words ();
    q4k_value_if dequant_vals ();

    q4k_block_dequantizer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .quant_words  (quant_words),
        .dequant_vals (dequant_vals)
    );

    q4k_dequant_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .words      (quant_words),
        .vals       (dequant_vals),
        .mismatches (value_mismatches),
        .pending    (values_pending),
        .checked    (values_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Input gap: mostly none, sometimes a short one, rarely a long pause.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Super scale / super min: the signed extremes, zero and -1 show up often.
    function automatic logic [FIX_W-1:0] pick_fix();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return FIX_W'($urandom);
        endcase
    endfunction

    // Push block_words through the input channel. The valid flag is only
    // lowered when a gap is inserted, so back-to-back words keep it high.
    task automatic send_block(input bit no_gaps);
        for (int k = 0; k < WORDS_PER_BLOCK; k++)
        begin
            repeat (no_gaps ? 0 : idle_len())
            begin
                @(negedge clk);
                quant_words.valid <= 1'b0;
            end
            @(negedge clk);
            quant_words.valid     <= 1'b1;
            quant_words.data_word <= block_words[k];
            do
                @(posedge clk);
            while (!quant_words.ready);
        end
        blocks_sent++;
    endtask

    // Output backpressure: ready bursts of random length, stalls mostly short,
    // a few long ones, and now and then a long stretch with no stall at all.
    initial
    begin
        int run;
        int hold;
        dequant_vals.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run  = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 500)
                                               : $urandom_range(1, 12);
            hold = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                : $urandom_range(20, 100);
            repeat (run)
            begin
                @(negedge clk);
                dequant_vals.ready <= 1'b1;
            end
            repeat (hold)
            begin
                @(negedge clk);
                dequant_vals.ready <= 1'b0;
            end
        end
    end

    initial
    begin
        logic [FIX_W-1:0] d_fix;
        logic [FIX_W-1:0] dmin_fix;
        logic [7:0]       sb [12];
        bit               corner;
        int               r;

        quant_words.valid     = 1'b0;
        quant_words.data_word = '0;
        blocks_sent           = 0;
        rst_n                 = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed block: largest positive d, most negative dmin, every scale
        // and min at 63, and nibbles 0 and 15 in both halves. Reaches the top
        // of the value range; the next block checks the wrap back to word 0.
        block_words[0] = {32'hFFFF_FFFF, 16'h8000, 16'h7FFF};
        block_words[1] = '1;
        for (int k = 2; k < WORDS_PER_BLOCK; k++)
        begin
            case ((k - 2) % 4)
                0:       block_words[k] = '1;
                1:       block_words[k] = '0;
                2:       block_words[k] = {8{8'hF0}};
                default: block_words[k] = {8{8'h0F}};
            endcase
        end
        send_block(1'b0);

        // Random blocks. A quarter are corner blocks: opposite-sign extremes of
        // d and dmin, full scale bytes and half all-ones nibble words, which hits
        // the bottom of the value range when d is negative.
        for (int b = 0; b < RANDOM_BLOCKS; b++)
        begin
            corner = ($urandom_range(0, 3) == 0);
            if (corner)
            begin
                d_fix    = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                dmin_fix = (d_fix == 16'h8000) ? 16'h7FFF : 16'h8000;
            end
            else
            begin
                d_fix    = pick_fix();
                dmin_fix = pick_fix();
            end
            for (int i = 0; i < 12; i++)
            begin
                r = $urandom_range(0, 9);
                sb[i] = (corner || r < 2) ? 8'hFF : (r < 3) ? 8'h00 : 8'($urandom);
            end
            block_words[0] = {sb[3], sb[2], sb[1], sb[0], dmin_fix, d_fix};
            block_words[1] = {sb[11], sb[10], sb[9], sb[8], sb[7], sb[6], sb[5], sb[4]};
            for (int k = 2; k < WORDS_PER_BLOCK; k++)
            begin
                r = $urandom_range(0, 9);
                if ((corner && r < 5) || r == 0)
                    block_words[k] = '1;
                else if (r == 1)
                    block_words[k] = '0;
                else
                    block_words[k] = {$urandom, $urandom};
            end
            // every third block goes in back to back
            send_block(b % 3 == 1);
        end

        @(negedge clk);
        quant_words.valid <= 1'b0;

        // everything predicted has to come out, then nothing more may follow
        wait (values_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d super-blocks (%0d words): one directed, the rest random,",
                 blocks_sent, blocks_sent * WORDS_PER_BLOCK);
        $display("with input gaps and output stalls; checked %0d values, %0d mismatches.",
                 values_checked, value_mismatches);
        if (value_mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (every value held by the
    // longest output stall, every word by the longest input gap).
    initial
    begin
        #5_000_000;
        $display("Timeout: %0d values still pending after %0d checked.",
                 values_pending, values_checked);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
